>>> sv/ipv4p_pkg.sv
// Shared types and constants for the IPv4 dotted-address parser.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

	typedef struct packed {
		logic [7:0] character;
	} char_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] address;
	} res_t;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_ZERO   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DRAIN  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	// Upper bound of the last part for two, three and four parts.
	localparam logic [31:0] LAST_MAX_2 = 32'h00ff_ffff;
	localparam logic [31:0] LAST_MAX_3 = 32'h0000_ffff;
	localparam logic [31:0] LAST_MAX_4 = 32'h0000_00ff;

	localparam logic [1:0] PARTS_MAX = 2'd3;

endpackage

`default_nettype wire

>>> sv/ipv4p_stream_if.sv
// Valid/ready channel interfaces for text bytes and parse results.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_char_if;
	logic             valid;
	logic             ready;
	ipv4p_pkg::char_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ipv4p_res_if;
	logic            valid;
	logic            ready;
	ipv4p_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/ipv4p_in_reg.sv
// Input register stage holding one text byte.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_in_reg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ipv4p_char_if.sink        chars,
	input  wire logic         advance,
	output logic              valid_s1,
	output ipv4p_pkg::char_t  char_s1
);

	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.data;
		end
	end

endmodule

`default_nettype wire

>>> sv/ipv4p_parse.sv
// Parse state machine: per-byte accumulate, part capture and address composition.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_parse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  character,
	output logic             emit,
	output ipv4p_pkg::res_t  res
);

	ipv4p_pkg::phase_t phase_q, phase_n;
	ipv4p_pkg::radix_t radix_q, radix_n;
	logic [31:0] acc_q, acc_n;
	logic [1:0]  parts_q, parts_n;
	logic [31:0] earlier_q [3];

	logic        is_dig, is_hex_letter, is_space, part_wr;
	logic [3:0]  dig_val;
	logic [31:0] acc_mul, acc_digit, composed;
	logic        compose_ok;

	always_comb begin
		is_dig        = (character >= ipv4p_pkg::CH_ZERO) && (character <= ipv4p_pkg::CH_NINE);
		is_hex_letter = ((character >= ipv4p_pkg::CH_A_LO) && (character <= ipv4p_pkg::CH_F_LO))
		             || ((character >= ipv4p_pkg::CH_A_UP) && (character <= ipv4p_pkg::CH_F_UP));
		is_space      = (character == ipv4p_pkg::CH_SPACE)
		             || ((character >= ipv4p_pkg::CH_TAB) && (character <= ipv4p_pkg::CH_CR));
		// letters a-f / A-F have low nibble 1..6
		dig_val       = is_dig ? character[3:0] : character[3:0] + 4'd9;

		case (radix_q)
			ipv4p_pkg::RADIX_HEX: acc_mul = {acc_q[27:0], 4'b0};
			ipv4p_pkg::RADIX_OCT: acc_mul = {acc_q[28:0], 3'b0};
			default:              acc_mul = {acc_q[28:0], 3'b0} + {acc_q[30:0], 1'b0};
		endcase
		acc_digit = acc_mul + {28'b0, dig_val};

		case (parts_q)
			2'd0: begin
				compose_ok = 1'b1;
				composed   = acc_q;
			end
			2'd1: begin
				compose_ok = acc_q <= ipv4p_pkg::LAST_MAX_2;
				composed   = acc_q | {earlier_q[0][7:0], 24'b0};
			end
			2'd2: begin
				compose_ok = acc_q <= ipv4p_pkg::LAST_MAX_3;
				composed   = acc_q | {earlier_q[0][7:0], 24'b0} | {earlier_q[1][15:0], 16'b0};
			end
			default: begin
				compose_ok = acc_q <= ipv4p_pkg::LAST_MAX_4;
				composed   = acc_q | {earlier_q[0][7:0], 24'b0} | {earlier_q[1][15:0], 16'b0}
				           | {earlier_q[2][23:0], 8'b0};
			end
		endcase
	end

	always_comb begin
		phase_n       = phase_q;
		radix_n       = radix_q;
		acc_n         = acc_q;
		parts_n       = parts_q;
		part_wr       = 1'b0;
		emit          = 1'b0;
		res.valid_res = 1'b0;
		res.address   = '0;

		case (phase_q)
			ipv4p_pkg::PH_START: begin
				if (!is_dig) begin
					emit = 1'b1;
				end else if (character == ipv4p_pkg::CH_ZERO) begin
					acc_n   = '0;
					radix_n = ipv4p_pkg::RADIX_OCT;
					phase_n = ipv4p_pkg::PH_ZERO;
				end else begin
					acc_n   = {28'b0, dig_val};
					radix_n = ipv4p_pkg::RADIX_DEC;
					phase_n = ipv4p_pkg::PH_DIGITS;
				end
			end
			ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS: begin
				phase_n = ipv4p_pkg::PH_DIGITS;
				if (phase_q == ipv4p_pkg::PH_ZERO
				    && (character == ipv4p_pkg::CH_X_LO || character == ipv4p_pkg::CH_X_UP)) begin
					radix_n = ipv4p_pkg::RADIX_HEX;
				end else if (is_dig || (is_hex_letter && radix_q == ipv4p_pkg::RADIX_HEX)) begin
					acc_n = acc_digit;
				end else if (character == ipv4p_pkg::CH_DOT) begin
					if (parts_q == ipv4p_pkg::PARTS_MAX) begin
						emit = 1'b1;
					end else begin
						part_wr = 1'b1;
						parts_n = parts_q + 2'd1;
						acc_n   = '0;
						radix_n = ipv4p_pkg::RADIX_DEC;
						phase_n = ipv4p_pkg::PH_START;
					end
				end else if (character == ipv4p_pkg::CH_NUL || is_space) begin
					emit          = 1'b1;
					res.valid_res = compose_ok;
					res.address   = compose_ok ? composed : '0;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				if (character == ipv4p_pkg::CH_NUL) begin
					radix_n = ipv4p_pkg::RADIX_DEC;
					acc_n   = '0;
					parts_n = '0;
					phase_n = ipv4p_pkg::PH_START;
				end
			end
		endcase

		if (emit) begin
			radix_n = ipv4p_pkg::RADIX_DEC;
			acc_n   = '0;
			parts_n = '0;
			phase_n = (character == ipv4p_pkg::CH_NUL) ? ipv4p_pkg::PH_START
			                                           : ipv4p_pkg::PH_DRAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ipv4p_pkg::PH_START;
			radix_q <= ipv4p_pkg::RADIX_DEC;
			acc_q   <= '0;
			parts_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			radix_q <= radix_n;
			acc_q   <= acc_n;
			parts_q <= parts_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && part_wr) begin
			earlier_q[parts_q] <= acc_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/ipv4p_out_reg.sv
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire ipv4p_pkg::res_t  d,
	output logic                  free,
	ipv4p_res_if.source           results
);

	logic            valid_q;
	ipv4p_pkg::res_t data_q;

	assign free          = !valid_q || results.ready;
	assign results.valid = valid_q;
	assign results.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

`default_nettype wire

>>> sv/ipv4_dotted_address_parser_core.sv
// Top level of the streaming IPv4 dotted-address parser.
// A byte that ends a parse is held in the input register; its result is then loaded into the
// output register, which drives the port until the result is taken.
// Throughput: one text byte per cycle while the output register is empty or its result is being taken.
// A result waiting in the output register stalls input only once the input register is full.
// Reset clears the parse state to the start of an address and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_address_parser_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ipv4p_char_if.sink  chars,
	ipv4p_res_if.source results
);

	logic             valid_s1;
	ipv4p_pkg::char_t char_s1;
	logic             free;
	logic             step;
	logic             emit;
	ipv4p_pkg::res_t  res;

	assign step = valid_s1 && free;

	ipv4p_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (step),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1)
	);

	ipv4p_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.character (char_s1.character),
		.emit      (emit),
		.res       (res)
	);

	ipv4p_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && emit),
		.d       (res),
		.free    (free),
		.results (results)
	);

endmodule

`default_nettype wire

>>> sv/ipv4p_checker.sv
// Port-level assertions for the parser top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_valid_res,
	input wire logic [31:0] out_address
);

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_valid_res |-> out_address == 32'd0)
		else $error("rejected address carries nonzero value");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_valid_res) && $stable(out_address))
		else $error("stalled result changed");

endmodule

bind ipv4_dotted_address_parser_core ipv4p_checker u_ipv4p_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (chars.valid),
	.in_ready      (chars.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_valid_res (results.data.valid_res),
	.out_address   (results.data.address)
);

`default_nettype wire

>>> dv/ipv4p_parse_checker.sv
// Checker for the IPv4 parser: predicts verdicts from accepted bytes and compares results.
`timescale 1ns / 1ps

module ipv4p_parse_checker (
	input  logic  clk,
	input  logic  arst_n,
	ipv4p_char_if chars,
	ipv4p_res_if  results,
	output int    fail_count,
	output int    verdicts_pending
);
	import ipv4p_pkg::*;

	phase_t      ph = PH_START;
	radix_t      radix = RADIX_DEC;
	logic [31:0] acc = '0;
	logic [31:0] parts [3] = '{default: '0};
	logic [1:0]  nparts = '0;
	res_t        expected_verdicts [$];
	int          errors = 0;
	int          pending_n = 0;

	assign fail_count = errors;
	assign verdicts_pending = pending_n;

	function automatic logic is_dec(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic give_verdict(input logic [7:0] c, input logic ok, input logic [31:0] addr);
		res_t r;
		r.valid_res = ok;
		r.address = ok ? addr : 32'h0;
		expected_verdicts.push_back(r);
		radix = RADIX_DEC;
		acc = '0;
		nparts = '0;
		ph = (c == CH_NUL) ? PH_START : PH_DRAIN;
	endtask

	// last part stays in acc; earlier parts are shifted in and truncated
	task automatic end_address(input logic [7:0] c);
		logic [31:0] v;
		logic ok;
		ok = 1'b1;
		v = acc;
		case (nparts)
			2'd1: begin
				ok = acc <= LAST_MAX_2;
				v = acc | (parts[0] << 24);
			end
			2'd2: begin
				ok = acc <= LAST_MAX_3;
				v = acc | (parts[0] << 24) | (parts[1] << 16);
			end
			2'd3: begin
				ok = acc <= LAST_MAX_4;
				v = acc | (parts[0] << 24) | (parts[1] << 16) | (parts[2] << 8);
			end
			default: ;
		endcase
		give_verdict(c, ok, v);
	endtask

	task automatic parse_char(input logic [7:0] c);
		logic [31:0] base;
		if (ph == PH_START) begin
			if (!is_dec(c)) begin
				give_verdict(c, 1'b0, '0);
			end else if (c == CH_ZERO) begin
				acc = '0;
				radix = RADIX_OCT;
				ph = PH_ZERO;
			end else begin
				acc = 32'(c - CH_ZERO);
				radix = RADIX_DEC;
				ph = PH_DIGITS;
			end
		end else if (ph == PH_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
			radix = RADIX_HEX;
			ph = PH_DIGITS;
		end else if (ph == PH_ZERO || ph == PH_DIGITS) begin
			ph = PH_DIGITS;
			base = (radix == RADIX_HEX) ? 32'd16 : (radix == RADIX_OCT) ? 32'd8 : 32'd10;
			if (is_dec(c)) begin
				acc = acc * base + 32'(c - CH_ZERO);
			end else if (radix == RADIX_HEX && c >= CH_A_LO && c <= CH_F_LO) begin
				acc = (acc << 4) | 32'(c - CH_A_LO + 8'd10);
			end else if (radix == RADIX_HEX && c >= CH_A_UP && c <= CH_F_UP) begin
				acc = (acc << 4) | 32'(c - CH_A_UP + 8'd10);
			end else if (c == CH_DOT) begin
				if (nparts == PARTS_MAX) begin
					give_verdict(c, 1'b0, '0);
				end else begin
					parts[nparts] = acc;
					nparts = nparts + 2'd1;
					acc = '0;
					radix = RADIX_DEC;
					ph = PH_START;
				end
			end else if (c == CH_NUL || is_blank(c)) begin
				end_address(c);
			end else begin
				give_verdict(c, 1'b0, '0);
			end
		end else if (c == CH_NUL) begin
			radix = RADIX_DEC;
			acc = '0;
			nparts = '0;
			ph = PH_START;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: result with none expected: valid_res=%0b address=%h",
						$time, results.data.valid_res, results.data.address);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (results.data.valid_res !== want.valid_res) begin
						$display("%0t: valid_res expected %0b, got %0b",
							$time, want.valid_res, results.data.valid_res);
						errors++;
					end
					if (results.data.address !== want.address) begin
						$display("%0t: address expected %h, got %h",
							$time, want.address, results.data.address);
						errors++;
					end
				end
			end
			if (chars.valid && chars.ready)
				parse_char(chars.data.character);
			pending_n = expected_verdicts.size();
		end
	end

endmodule

>>> dv/testbench.sv
// Testbench top for the IPv4 parser: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module testbench;
	import ipv4p_pkg::*;

	localparam int ITEMS = 1000;
	localparam int CYCLE_LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	int         cycles = 0;
	int         fail_count;
	int         verdicts_pending;
	int         sent = 0;
	int         stall_left = 0;
	bit         src_gaps = 1'b0;
	bit         sink_stalls = 1'b0;
	logic [7:0] text [$];

	ipv4p_char_if chars_if ();
	ipv4p_res_if  res_if ();

	ipv4_dotted_address_parser_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if)
	);

	ipv4p_parse_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.chars            (chars_if),
		.results          (res_if),
		.fail_count       (fail_count),
		.verdicts_pending (verdicts_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result sink: mostly short stalls, a few long ones
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (arst_n && sink_stalls && $urandom_range(0, 99) < 15) begin
			res_if.ready <= 1'b0;
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!src_gaps || r < 60)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called and returns at a falling edge; valid stays high between back-to-back transfers
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			chars_if.data <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.data <= c;
		do @(posedge clk); while (!chars_if.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text();
		foreach (text[i])
			send_char(text[i]);
		text.delete();
	endtask

	task automatic hold_off();
		chars_if.valid <= 1'b0;
		wait (verdicts_pending == 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return CH_ZERO + 8'(r);
		if (r < 16)
			return CH_A_LO + 8'(r - 10);
		return CH_A_UP + 8'(r - 16);
	endfunction

	task automatic add_part();
		radix_t kind;
		int     len;
		kind = radix_t'($urandom_range(0, 2));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
		case (kind)
			RADIX_DEC: begin
				text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				repeat (len) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			RADIX_OCT: begin
				text.push_back(CH_ZERO);
				repeat (len)
					text.push_back(CH_ZERO + 8'(($urandom_range(0, 9) == 0) ?
						$urandom_range(8, 9) : $urandom_range(0, 7)));
			end
			default: begin
				text.push_back(CH_ZERO);
				text.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
				repeat (len) text.push_back(hex_char());
			end
		endcase
	endtask

	task automatic add_blank();
		int r;
		r = $urandom_range(0, 5);
		text.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
	endtask

	task automatic build_address();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// noise
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
			text.push_back(CH_NUL);
			return;
		end
		n = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
		for (int p = 0; p < n; p++) begin
			if (p > 0)
				text.push_back(CH_DOT);
			add_part();
		end
		if (r < 16)
			text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		else if (r < 20)
			text.push_back(CH_DOT);
		r = $urandom_range(0, 9);
		if (r < 6) begin
			text.push_back(CH_NUL);
		end else begin
			if (r < 8)
				add_blank();
			else
				text.push_back(8'($urandom_range(1, 255)));
			repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(1, 255)));
			text.push_back(CH_NUL);
		end
	endtask

	initial begin
		chars_if.valid = 1'b0;
		chars_if.data = '0;
		res_if.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty string, octal 8/9 with blank end and drain, empty hex, trailing dot,
		// dot after a fourth part, hex in both cases, non-ASCII byte
		text = '{CH_NUL,
			CH_ZERO, CH_NINE, "8", CH_SPACE, 8'hff, CH_NUL,
			CH_ZERO, CH_X_LO, CH_NUL,
			"1", CH_DOT, CH_NUL,
			"0", CH_DOT, "0", CH_DOT, "0", CH_DOT, "0", CH_DOT, CH_NUL,
			CH_ZERO, CH_X_UP, CH_F_LO, CH_A_UP, CH_NUL,
			"9", 8'h80, CH_NUL};
		send_text();
		hold_off();

		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		while (sent < ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				src_gaps = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			build_address();
			send_text();
			if ($urandom_range(0, 29) == 0)
				hold_off();
		end

		chars_if.valid <= 1'b0;
		wait (verdicts_pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> ipv4_dotted_address_parser_core.f
sv/ipv4p_pkg.sv
sv/ipv4p_stream_if.sv
sv/ipv4p_in_reg.sv
sv/ipv4p_parse.sv
sv/ipv4p_out_reg.sv
sv/ipv4_dotted_address_parser_core.sv
sv/ipv4p_checker.sv
dv/ipv4p_parse_checker.sv
dv/testbench.sv
